>>> sv/roman_numeral_parser_defines.svh
// Assertion helpers shared by the parser RTL.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef ROMAN_NUMERAL_PARSER_DEFINES_SVH
`define ROMAN_NUMERAL_PARSER_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define RNP_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define RNP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/rnp_pkg.sv
package rnp_pkg;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_OPEN     = 3'd2;
  localparam logic [2:0] ST_M_AFTER  = 3'd3;
  localparam logic [2:0] ST_SYNTAX   = 3'd4;
  localparam logic [2:0] ST_FRACTION = 3'd5;

  // Progress of the match against the word "nulla".
  localparam logic [2:0] ZW_FULL = 3'd5;
  localparam logic [2:0] ZW_DEAD = 3'd7;

  // Where the parser stands in the grammar.
  typedef enum logic [3:0] {
    K_WS,
    K_SIGN,
    K_CLOSE,
    K_POSTV,
    K_TWS,
    K_DOTS,
    K_DRAIN,
    K_MGRP,
    K_SUB0,
    K_SUB1,
    K_SUB2
  } phase_kind_t;

  typedef struct packed {
    phase_kind_t kind;
    logic [1:0]  grp;    // 0 hundreds, 1 tens, 2 units
    logic        inner;  // inside an open vinculum
    logic [2:0]  rpt;    // repeat or dot count
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_NEG,
    ACT_ADD,
    ACT_VINC,
    ACT_HALF,
    ACT_DOT,
    ACT_FAIL
  } act_t;

  // Outcome of one nonzero character.
  typedef struct packed {
    phase_t     ph;
    act_t       act;
    logic [9:0] amount;
    logic [2:0] code;
    logic [2:0] zw;
  } step_t;

  // Whole parse state of the numeral in progress.
  typedef struct packed {
    phase_t      ph;
    logic [2:0]  err;
    logic [2:0]  zw;
    logic        neg;
    logic [3:0]  tw;
    logic [21:0] total;
  } parse_t;

endpackage

>>> sv/roman_numeral_parser.sv
// Roman numeral parser.
// The input channel carries one text byte per beat on in_character; a zero
// byte ends the numeral. Each numeral yields exactly one result beat on the
// output channel: out_integer_value, out_twelfths and out_status.
// cfg_we with cfg_wdata sets the integer-only mode; write it only while idle.
// Throughput is one byte per cycle while in_stall is low. A byte is held in
// an input register and decoded in the next cycle against the parse state;
// the zero byte loads the result beat into the output register. The decode
// step walks the grammar positions that a byte may skip, at most eight, in
// logic between the input register and the parse state registers.
// Nonzero bytes keep flowing while a result waits to be taken. A zero byte
// waits in the input register only while the output register is full and
// stalled, and in_stall rises for that time.
// Reset (rst_n low, synchronous) clears the parse state, the mode register
// and both valid flags; no result is pending after reset.
`include "roman_numeral_parser_defines.svh"

module roman_numeral_parser import rnp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_character,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [22:0] out_integer_value,
  output logic signed [4:0]  out_twelfths,
  output logic [2:0]         out_status
);

  // State at reset and after every finished numeral.
  localparam parse_t PARSE_CLEAR = '{
    ph:    '{kind: K_WS, grp: 2'd0, inner: 1'b0, rpt: 3'd0},
    err:   ST_OK,
    zw:    3'd0,
    neg:   1'b0,
    tw:    4'd0,
    total: 22'd0
  };

  logic       req_int_r;
  logic [7:0] char_r;
  logic [7:0] char_nxt;
  logic       char_vld_r;
  logic       char_vld_nxt;
  parse_t     parse_r;
  parse_t     parse_nxt;
  step_t      step;
  logic       slot_free;
  logic       char_zero;
  logic       char_go;
  logic       zero_go;
  logic       in_accept;

  // The mode register takes its write at once; there is nothing to wait on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_int_r <= 1'b0;
    end else if (cfg_we) begin
      req_int_r <= cfg_wdata;
    end
  end

  // A nonzero byte always moves on. The end byte needs a free output
  // register, since it produces the result beat.
  assign char_zero = (char_r == 8'h00);
  assign char_go   = char_vld_r && !char_zero;
  assign zero_go   = char_vld_r && char_zero && slot_free;
  assign in_stall  = char_vld_r && char_zero && !slot_free;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    char_nxt     = char_r;
    char_vld_nxt = char_vld_r;
    if (in_accept) begin
      char_nxt     = in_character;
      char_vld_nxt = 1'b1;
    end else if (char_go || zero_go) begin
      char_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_vld_r <= 1'b0;
    end else begin
      char_vld_r <= char_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  rnp_step_decode u_decode (
    .character (char_r),
    .phase     (parse_r.ph),
    .zw        (parse_r.zw),
    .step      (step)
  );

  // Apply the decoded action. The vinculum close scales the running total
  // by a thousand; later groups then add straight onto it, which gives the
  // same sum as keeping the two parts apart.
  always_comb begin
    parse_nxt = parse_r;
    if (zero_go) begin
      parse_nxt = PARSE_CLEAR;
    end else if (char_go) begin
      parse_nxt.ph = step.ph;
      parse_nxt.zw = step.zw;
      unique case (step.act)
        ACT_NEG:  parse_nxt.neg   = 1'b1;
        ACT_ADD:  parse_nxt.total = parse_r.total + 22'(step.amount);
        ACT_VINC: parse_nxt.total = 22'(parse_r.total[11:0]) * 22'd1000;
        ACT_HALF: parse_nxt.tw    = 4'd6;
        ACT_DOT:  parse_nxt.tw    = parse_r.tw + 4'd1;
        ACT_FAIL: parse_nxt.err   = step.code;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parse_r <= PARSE_CLEAR;
    end else begin
      parse_r <= parse_nxt;
    end
  end

  rnp_result u_result (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (zero_go),
    .parse             (parse_r),
    .req_int           (req_int_r),
    .out_stall         (out_stall),
    .slot_free         (slot_free),
    .out_valid         (out_valid),
    .out_integer_value (out_integer_value),
    .out_twelfths      (out_twelfths),
    .out_status        (out_status)
  );

  // The draining position is only ever entered together with an error code.
  `RNP_ASSERT_NOW(a_drain_has_error, parse_r.ph.kind == K_DRAIN,
                  parse_r.err != ST_OK, "drain without error")
  // A half plus five dots is the most a numeral can carry.
  `RNP_ASSERT_NOW(a_twelfths_bound, 1'b1, parse_r.tw <= 4'd11,
                  "twelfth count out of range")
  // Inside the vinculum the total must fit the multiplier input.
  `RNP_ASSERT_NOW(a_inner_bound, parse_r.ph.inner, parse_r.total <= 22'd3999,
                  "vinculum part too large")
  // The end byte clears the parse and leaves a result beat behind.
  `RNP_ASSERT_NEXT(a_end_clears, zero_go,
                   out_valid && parse_r.ph.kind == K_WS && parse_r.total == 22'd0,
                   "end byte not retired")

endmodule

>>> sv/rnp_step_decode.sv
module rnp_step_decode import rnp_pkg::*; (
  input  logic [7:0] character,
  input  phase_t     phase,
  input  logic [2:0] zw,
  output step_t      step
);

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_M     = 8'h4D;
  // A byte falls through at most this many grammar positions.
  localparam int WALK_STEPS = 8;

  typedef struct packed {
    phase_t     ph;
    act_t       act;
    logic [9:0] amount;
    logic [2:0] code;
    logic       again;
  } walk_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
  endfunction

  function automatic logic [7:0] one_letter(input logic [1:0] g);
    case (g)
      2'd0:    return 8'h43;
      2'd1:    return 8'h58;
      2'd2:    return 8'h49;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] five_letter(input logic [1:0] g);
    case (g)
      2'd0:    return 8'h44;
      2'd1:    return 8'h4C;
      2'd2:    return 8'h56;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ten_letter(input logic [1:0] g);
    case (g)
      2'd0:    return 8'h4D;
      2'd1:    return 8'h43;
      2'd2:    return 8'h58;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [9:0] unit_value(input logic [1:0] g);
    case (g)
      2'd0:    return 10'd100;
      2'd1:    return 10'd10;
      2'd2:    return 10'd1;
      default: return 10'd0;
    endcase
  endfunction

  function automatic logic [7:0] zero_word(input logic [2:0] idx);
    case (idx)
      3'd0:    return 8'h4E;
      3'd1:    return 8'h55;
      3'd2:    return 8'h4C;
      3'd3:    return 8'h4C;
      3'd4:    return 8'h41;
      default: return 8'h00;
    endcase
  endfunction

  // One grammar position: either takes the byte or hands it on.
  function automatic walk_t walk(input phase_t ph, input logic [7:0] c,
                                 input logic [7:0] u, input logic sp);
    walk_t      w;
    phase_t     nxt;
    logic [9:0] uv;
    w.ph     = ph;
    w.act    = ACT_NONE;
    w.amount = 10'd0;
    w.code   = ST_OK;
    w.again  = 1'b0;
    uv       = unit_value(ph.grp);
    nxt      = ph;
    if (ph.grp == 2'd2) begin
      nxt.kind = ph.inner ? K_CLOSE : K_TWS;
    end else begin
      nxt.kind = K_SUB0;
      nxt.grp  = ph.grp + 2'd1;
    end
    unique case (ph.kind)
      K_WS: begin
        if (!sp) begin
          w.ph.kind = K_SIGN;
          if (c == CH_MINUS) w.act = ACT_NEG;
          else w.again = 1'b1;
        end
      end
      K_SIGN: begin
        w.ph.rpt  = 3'd0;
        w.ph.kind = K_MGRP;
        w.ph.grp  = 2'd0;
        if (c == CH_US) w.ph.inner = 1'b1;
        else begin
          w.ph.inner = 1'b0;
          w.again    = 1'b1;
        end
      end
      K_CLOSE: begin
        if (c == CH_US) begin
          w.act      = ACT_VINC;
          w.ph.kind  = K_POSTV;
          w.ph.inner = 1'b0;
        end else begin
          w.act     = ACT_FAIL;
          w.code    = ST_OPEN;
          w.ph.kind = K_DRAIN;
        end
      end
      K_POSTV: begin
        if (u == CH_M) begin
          w.act     = ACT_FAIL;
          w.code    = ST_M_AFTER;
          w.ph.kind = K_DRAIN;
        end else begin
          w.ph.kind  = K_SUB0;
          w.ph.grp   = 2'd0;
          w.ph.inner = 1'b0;
          w.again    = 1'b1;
        end
      end
      K_TWS: begin
        w.ph.kind = K_DOTS;
        w.ph.rpt  = 3'd0;
        if (u == CH_S) w.act = ACT_HALF;
        else w.again = 1'b1;
      end
      K_DOTS: begin
        if ((c == CH_DOT) && (ph.rpt < 3'd5)) begin
          w.act    = ACT_DOT;
          w.ph.rpt = ph.rpt + 3'd1;
        end else begin
          w.act     = ACT_FAIL;
          w.code    = ST_SYNTAX;
          w.ph.kind = K_DRAIN;
        end
      end
      K_MGRP: begin
        if ((u == CH_M) && (ph.rpt < 3'd3)) begin
          w.act    = ACT_ADD;
          w.amount = 10'd1000;
          w.ph.rpt = ph.rpt + 3'd1;
        end else begin
          w.ph.kind = K_SUB0;
          w.ph.grp  = 2'd0;
          w.again   = 1'b1;
        end
      end
      K_SUB0: begin
        if (u == one_letter(ph.grp)) begin
          w.act     = ACT_ADD;
          w.amount  = uv;
          w.ph.rpt  = 3'd1;
          w.ph.kind = K_SUB1;
        end else if (u == five_letter(ph.grp)) begin
          w.act     = ACT_ADD;
          w.amount  = 10'(uv * 10'd5);
          w.ph.rpt  = 3'd0;
          w.ph.kind = K_SUB2;
        end else begin
          w.ph    = nxt;
          w.again = 1'b1;
        end
      end
      K_SUB1: begin
        // Subtractive pairs add the rest of nine or four.
        if (u == ten_letter(ph.grp)) begin
          w.act    = ACT_ADD;
          w.amount = 10'(uv * 10'd8);
          w.ph     = nxt;
        end else if (u == five_letter(ph.grp)) begin
          w.act    = ACT_ADD;
          w.amount = 10'(uv * 10'd3);
          w.ph     = nxt;
        end else if (u == one_letter(ph.grp)) begin
          w.act     = ACT_ADD;
          w.amount  = uv;
          w.ph.rpt  = 3'd2;
          w.ph.kind = K_SUB2;
        end else begin
          w.ph    = nxt;
          w.again = 1'b1;
        end
      end
      K_SUB2: begin
        if ((u == one_letter(ph.grp)) && (ph.rpt < 3'd3)) begin
          w.act    = ACT_ADD;
          w.amount = uv;
          w.ph.rpt = ph.rpt + 3'd1;
        end else begin
          w.ph    = nxt;
          w.again = 1'b1;
        end
      end
      K_DRAIN: begin
      end
      default: begin
        w.ph.kind = K_DRAIN;
      end
    endcase
    return w;
  endfunction

  always_comb begin
    walk_t      w;
    logic [7:0] u;
    logic       sp;
    u  = to_upper(character);
    sp = is_space(character);
    w  = '{ph: phase, act: ACT_NONE, amount: 10'd0, code: ST_OK, again: 1'b1};
    for (int i = 0; i < WALK_STEPS; i++) begin
      if (w.again) w = walk(w.ph, character, u, sp);
    end
    step.ph     = w.ph;
    step.act    = w.act;
    step.amount = w.amount;
    step.code   = w.code;
    // Leading whitespace does not take part in the "nulla" match.
    if ((phase.kind == K_WS) && sp) step.zw = zw;
    else if ((zw < ZW_FULL) && (u == zero_word(zw))) step.zw = zw + 3'd1;
    else step.zw = ZW_DEAD;
  end

endmodule

>>> sv/rnp_result.sv
module rnp_result import rnp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  parse_t             parse,
  input  logic               req_int,
  input  logic               out_stall,
  output logic               slot_free,
  output logic               out_valid,
  output logic signed [22:0] out_integer_value,
  output logic signed [4:0]  out_twelfths,
  output logic [2:0]         out_status
);

  logic               valid_r;
  logic signed [22:0] int_r;
  logic signed [4:0]  tw_r;
  logic [2:0]         st_r;
  logic [22:0]        mag;
  logic [4:0]         tw5;
  logic [2:0]         st;

  assign slot_free = !valid_r || !out_stall;

  always_comb begin
    st  = ST_OK;
    mag = 23'd0;
    tw5 = 5'd0;
    if (parse.ph.kind == K_WS) begin
      st = ST_EMPTY;
    end else if (parse.zw == ZW_FULL) begin
      st = ST_OK;
    end else if (parse.err != ST_OK) begin
      st = parse.err;
    end else if ((parse.ph.kind == K_CLOSE) || parse.ph.inner) begin
      // Any position still inside the vinculum means it was never closed.
      st = ST_OPEN;
    end else begin
      mag = {1'b0, parse.total};
      tw5 = {1'b0, parse.tw};
      if (req_int && (parse.tw != 4'd0)) begin
        st  = ST_FRACTION;
        mag = 23'd0;
        tw5 = 5'd0;
      end
    end
    if (parse.neg) begin
      mag = 23'd0 - mag;
      tw5 = 5'd0 - tw5;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      int_r <= mag;
      tw_r  <= tw5;
      st_r  <= st;
    end
  end

  assign out_valid         = valid_r;
  assign out_integer_value = int_r;
  assign out_twelfths      = tw_r;
  assign out_status        = st_r;

endmodule
